// File: sv/bdlp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the push-button debouncer with long press.
// No dependencies; imported by bdlp_countdown and button_debounce_long_press.
package bdlp_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Event codes; the button state uses the same coding.
  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_LONG     = 2'd2
  } ev_code_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TICKS = 3'd0,
    CFG_LONG_TICKS     = 3'd1,
    CFG_EVENT_MASK     = 3'd2,
    CFG_ACTIVE_LOW     = 3'd3,
    CFG_ENABLE         = 3'd4
  } cfg_idx_t;

  localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd50;
  localparam logic [15:0] LONG_TICKS_RST     = 16'd1000;
  localparam logic [2:0]  EVENT_MASK_RST     = 3'b111;
  localparam logic        ACTIVE_LOW_RST     = 1'b0;
  localparam logic        ENABLE_RST         = 1'b1;

  // Countdown control: stop wins over arm, arm wins over tick.
  typedef struct packed {
    logic arm;
    logic tick;
    logic stop;
  } cnt_ctrl_t;

  typedef struct packed {
    logic running;
    logic due;      // running and the next tick expires it
  } cnt_stat_t;

endpackage

// File: sv/bdlp_countdown.sv
`timescale 1ns / 1ps
// One-shot tick countdown with arm, tick and stop controls.
// Depends on bdlp_pkg for the control and status structs.
module bdlp_countdown
  import bdlp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cnt_ctrl_t              ctrl,
  input  logic [COUNT_WIDTH-1:0] load_val,
  output cnt_stat_t              stat
);

  logic                   running_r, running_nxt;
  logic [COUNT_WIDTH-1:0] left_r, left_nxt;
  logic                   due;

  // Expires on the tick where the count would reach zero; a load of 0 acts like 1.
  assign due = running_r && (left_r <= COUNT_WIDTH'(1));

  always_comb begin
    running_nxt = running_r;
    left_nxt    = left_r;
    priority if (ctrl.stop) begin
      running_nxt = 1'b0;
      left_nxt    = '0;
    end else if (ctrl.arm) begin
      running_nxt = 1'b1;
      left_nxt    = load_val;
    end else if (ctrl.tick && running_r) begin
      if (due) begin
        running_nxt = 1'b0;
        left_nxt    = '0;
      end else begin
        left_nxt = left_r - COUNT_WIDTH'(1);
      end
    end else begin
      // Hold the count.
      running_nxt = running_r;
      left_nxt    = left_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
  end

  assign stat.running = running_r;
  assign stat.due     = due;

endmodule

// File: sv/button_debounce_long_press.sv
`timescale 1ns / 1ps
// Push-button debouncer with long-press detection. An accepted input transaction passes
// the input register, then the result register, to become its result transaction.
// One input transaction per cycle unless stalled; each tick yields at most one result.
// Reset (rst_n low, synchronous): both countdowns stopped, button released,
// configuration back to debounce 50, long press 1000, mask 7, active high, enabled.
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic                  in_pin_level,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_code,
  output logic                  out_held_status,
  output logic                  out_last_event
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] debounce_ticks_r;
  logic [15:0] long_ticks_r;
  logic [2:0]  event_mask_r;
  logic        active_low_r;
  logic        enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_TICKS_RST;
      long_ticks_r     <= LONG_TICKS_RST;
      event_mask_r     <= EVENT_MASK_RST;
      active_low_r     <= ACTIVE_LOW_RST;
      enable_r         <= ENABLE_RST;
    end else if (cfg_we) begin
      // Drop writes to indexes beyond the register list.
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_TICKS: debounce_ticks_r <= cfg_wdata;
        CFG_LONG_TICKS:     long_ticks_r     <= cfg_wdata;
        CFG_EVENT_MASK:     event_mask_r     <= cfg_wdata[2:0];
        CFG_ACTIVE_LOW:     active_low_r     <= cfg_wdata[0];
        CFG_ENABLE:         enable_r         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic s1_action_r;
  logic s1_level_r;
  logic s1_adv;       // stage 1 transaction is processed this cycle
  logic out_free;     // result register can take a new result this cycle

  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_action_r <= in_action;
      s1_level_r  <= in_pin_level;
    end
  end

  // ---------------------------------------------------------------------
  // Countdowns
  // ---------------------------------------------------------------------
  cnt_ctrl_t deb_ctrl, long_ctrl;
  cnt_stat_t deb_stat, long_stat;

  bdlp_countdown #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_deb_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (deb_ctrl),
    .load_val (COUNT_WIDTH'(debounce_ticks_r)),
    .stat     (deb_stat)
  );

  bdlp_countdown #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_long_cnt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (long_ctrl),
    .load_val (COUNT_WIDTH'(long_ticks_r)),
    .stat     (long_stat)
  );

  // ---------------------------------------------------------------------
  // Event logic for the transaction held in stage 1
  // ---------------------------------------------------------------------
  logic     is_tick;
  logic     pressed;       // qualified pin level
  logic     deb_exp;
  logic     long_exp;
  logic     changed;
  logic     ev_hit;        // an event is raised this tick
  ev_code_t ev;
  logic     emit;          // raised event passes the mask
  logic     last_q_r, last_q_nxt;
  ev_code_t btn_state_r, btn_state_nxt;
  logic     res_load;

  assign is_tick  = s1_valid_r && !s1_action_r;
  assign pressed  = s1_level_r ^ active_low_r;
  assign changed  = pressed != last_q_r;
  // Debounce expiry is handled first and keeps the long countdown from ticking.
  assign deb_exp  = is_tick && deb_stat.due;
  assign long_exp = is_tick && !deb_stat.due && long_stat.due;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ev_hit        = 1'b0;
    ev            = EV_RELEASED;
    last_q_nxt    = last_q_r;
    btn_state_nxt = btn_state_r;
    if (deb_exp) begin
      if (changed) begin
        ev_hit     = 1'b1;
        ev         = pressed ? EV_PRESSED : EV_RELEASED;
        last_q_nxt = pressed;
      end
      // No change forces the state to released.
      btn_state_nxt = (changed && pressed) ? EV_PRESSED : EV_RELEASED;
    end else if (long_exp) begin
      // Leave the qualified level untouched on a long-press check.
      ev_hit        = 1'b1;
      ev            = pressed ? EV_LONG : EV_RELEASED;
      btn_state_nxt = ev;
    end
  end

  assign emit     = ev_hit && event_mask_r[ev];
  // Hold stage 1 only when it has a result and the result register is full and stalled.
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign res_load = s1_adv && emit;

  always_comb begin
    deb_ctrl.arm   = s1_adv && s1_action_r && enable_r && !deb_stat.running;
    deb_ctrl.tick  = s1_adv && !s1_action_r;
    deb_ctrl.stop  = 1'b0;
    long_ctrl.arm  = s1_adv && deb_exp && changed && pressed;
    long_ctrl.stop = s1_adv && deb_exp && changed && !pressed;
    long_ctrl.tick = s1_adv && !s1_action_r && !deb_stat.due;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_q_r    <= 1'b0;
      btn_state_r <= EV_RELEASED;
    end else if (s1_adv) begin
      last_q_r    <= last_q_nxt;
      btn_state_r <= btn_state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic       out_valid_r;
  logic [1:0] out_event_code_r;
  logic       out_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_event_code_r <= ev;
      out_held_r       <= (btn_state_nxt == EV_PRESSED) || (btn_state_nxt == EV_LONG);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_code  = out_event_code_r;
  assign out_held_status = out_held_r;
  // A tick raises at most one event, so every result closes its transaction.
  assign out_last_event  = 1'b1;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_one_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    !(deb_exp && long_exp))
    else $error("debounce and long-press expiry in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_long_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (btn_state_r == EV_LONG) |-> !long_stat.running)
    else $error("long-press countdown running in long-pressed state");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && in_stall) |=> (s1_valid_r && $stable(s1_action_r)))
    else $error("stage 1 transaction lost while held");

endmodule
